// ===== sv/mpct_pkg.sv =====
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types, constants and arithmetic helpers for the mouse packet
// cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

   // Cursor register width
   localparam int POS_WIDTH = 8;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   // Working width of the cursor sum: room for 8-bit limits, sign and carry
   localparam int SUM_W = ((POS_WIDTH > 8) ? POS_WIDTH : 8) + 2;

   // Scaled step: at most 42 cells either way
   localparam int STEP_W = 7;

   // Reset values
   localparam int COL_RESET    = 40;
   localparam int ROW_RESET    = 12;
   localparam int MAXCOL_RESET = 79;
   localparam int MAXROW_RESET = 24;

   // X is divided by 4 (shift); Y by 3 through a reciprocal multiply,
   // exact for magnitudes up to 255
   localparam int X_SHIFT = 2;
   localparam int Y_RECIP = 171;
   localparam int Y_SHIFT = 9;

   // Command codes
   localparam logic CMD_MOUSE_BYTE = 1'b0;
   localparam logic CMD_SET_POS    = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROW = 2'd2;

   // Byte position within a packet
   localparam logic [1:0] BYTE_FIRST  = 2'd0;
   localparam logic [1:0] BYTE_SECOND = 2'd1;
   localparam logic [1:0] BYTE_THIRD  = 2'd2;

   // Stream widths
   localparam int REQ_W = 24;
   localparam int RSP_W = 40;

   typedef struct packed {
      logic       command;
      logic [7:0] new_row;
      logic [7:0] new_col;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       enable;
      logic [7:0] max_col;
      logic [7:0] max_row;
   } csr_type;

   // Scale a signed delta toward zero; a nonzero delta moves at least one cell
   function automatic logic signed [STEP_W-1:0] scale_step(
      input logic signed [8:0] d,
      input logic              by_three
   );
      logic [7:0]  mag;
      logic [16:0] prod;
      logic [7:0]  q;
      logic signed [STEP_W-1:0] s;
      mag  = d[8] ? 8'(-d) : d[7:0];
      prod = 17'(mag) * 17'(Y_RECIP);
      if (by_three) begin
         q = 8'(prod >> Y_SHIFT);
      end else begin
         q = 8'(mag >> X_SHIFT);
      end
      if (q == 8'd0 && mag != 8'd0) begin
         q = 8'd1;
      end
      s = $signed(STEP_W'(q));
      if (d[8]) begin
         s = -s;
      end
      return s;
   endfunction

   // Add a step to a cursor coordinate and clamp to 0..limit
   function automatic logic [POS_WIDTH-1:0] move_clamped(
      input logic [POS_WIDTH-1:0]     pos,
      input logic signed [STEP_W-1:0] step,
      input logic [7:0]               limit
   );
      logic signed [SUM_W-1:0] v;
      logic signed [SUM_W-1:0] lim;
      logic signed [SUM_W-1:0] lim_top;
      v       = $signed(SUM_W'(pos)) + SUM_W'(step);
      lim     = $signed(SUM_W'(limit));
      lim_top = $signed(SUM_W'(POS_MAX));
      if (lim > lim_top) begin
         lim = lim_top;
      end
      if (v < 0) begin
         v = '0;
      end
      if (v > lim) begin
         v = lim;
      end
      return POS_WIDTH'(v);
   endfunction

   // Low byte of a cursor coordinate
   function automatic logic [7:0] pos_byte(input logic [POS_WIDTH-1:0] p);
      return 8'(SUM_W'(p));
   endfunction

endpackage

// ===== sv/mpct_csr.sv =====
// ----------------------------------------------------------------------------
// mpct_csr
// Configuration registers: enable and cursor limits, written by index.
// ----------------------------------------------------------------------------
module mpct_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mpct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_wdata,
   output mpct_pkg::csr_type                cfg
);

   logic       enable_ff,  enable_in;
   logic [7:0] max_col_ff, max_col_in;
   logic [7:0] max_row_ff, max_row_in;

   // Decode the write
   always_comb begin
      enable_in  = enable_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (csr_we) begin
         unique case (csr_index)
            mpct_pkg::CSR_ENABLE:  enable_in  = csr_wdata[0];
            mpct_pkg::CSR_MAX_COL: max_col_in = csr_wdata;
            mpct_pkg::CSR_MAX_ROW: max_row_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         max_col_ff <= 8'(mpct_pkg::MAXCOL_RESET);
         max_row_ff <= 8'(mpct_pkg::MAXROW_RESET);
      end else begin
         enable_ff  <= enable_in;
         max_col_ff <= max_col_in;
         max_row_ff <= max_row_in;
      end
   end

   assign cfg.enable  = enable_ff;
   assign cfg.max_col = max_col_ff;
   assign cfg.max_row = max_row_ff;

endmodule

// ===== sv/mpct_in_stage.sv =====
// ----------------------------------------------------------------------------
// mpct_in_stage
// Input register: captures one transaction and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module mpct_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mpct_pkg::REQ_W-1:0]   req_tdata,
   input  logic                         req_tuser,
   output logic                         item_valid,
   output mpct_pkg::item_type           item,
   input  logic                         item_take
);

   logic               valid_ff, valid_in;
   mpct_pkg::item_type item_ff,  item_in;
   logic               accept;

   // Free when empty or when the held item leaves this cycle
   assign req_tready = !valid_ff || item_take;
   assign accept     = req_tvalid && req_tready;

   // Unpack and hold
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.command   = req_tuser;
         item_in.data_byte = req_tdata[7:0];
         item_in.new_col   = req_tdata[15:8];
         item_in.new_row   = req_tdata[23:16];
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/mpct_core.sv =====
// ----------------------------------------------------------------------------
// mpct_core
// Packet gathering, button and delta decode, cursor update, and the
// result register.
// ----------------------------------------------------------------------------
module mpct_core (
   input  logic                         clock,
   input  logic                         reset,
   input  mpct_pkg::csr_type            cfg,
   input  logic                         item_valid,
   input  mpct_pkg::item_type           item,
   output logic                         item_take,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mpct_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   localparam int PW = mpct_pkg::POS_WIDTH;

   // Packet state
   logic [1:0]        byte_index_ff,  byte_index_in;
   logic [7:0]        first_byte_ff,  first_byte_in;
   logic [7:0]        second_byte_ff, second_byte_in;
   logic [PW-1:0]     col_ff,         col_in;
   logic [PW-1:0]     row_ff,         row_in;
   logic [2:0]        btn_now_ff,     btn_now_in;
   logic [2:0]        btn_prev_ff,    btn_prev_in;
   logic signed [7:0] last_dx_ff,     last_dx_in;
   logic signed [8:0] last_dy_ff,     last_dy_in;

   // Result register
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic                       rsp_tlast_ff,  rsp_tlast_in;
   logic [mpct_pkg::RSP_W-1:0] rsp_tdata_ff,  rsp_tdata_in;

   logic                                load;
   logic                                done;
   logic signed [7:0]                   dx_new;
   logic signed [8:0]                   dy_new;
   logic signed [mpct_pkg::STEP_W-1:0]  step_x;
   logic signed [mpct_pkg::STEP_W-1:0]  step_y;

   // Take an item when the result register is free or draining
   assign item_take = !rsp_tvalid_ff || rsp_tready;
   assign load      = item_valid && item_take;

   // Decode the closing byte of a packet
   assign dx_new = $signed(second_byte_ff);
   assign dy_new = -$signed({item.data_byte[7], item.data_byte});
   assign step_x = mpct_pkg::scale_step(9'(dx_new), 1'b0);
   assign step_y = mpct_pkg::scale_step(dy_new, 1'b1);

   // Advance packet state
   always_comb begin
      byte_index_in  = byte_index_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      btn_now_in     = btn_now_ff;
      btn_prev_in    = btn_prev_ff;
      last_dx_in     = last_dx_ff;
      last_dy_in     = last_dy_ff;
      done           = 1'b0;
      if (load) begin
         priority if (item.command == mpct_pkg::CMD_SET_POS) begin
            col_in = PW'(item.new_col);
            row_in = PW'(item.new_row);
         end else if (cfg.enable) begin
            priority if (byte_index_ff == mpct_pkg::BYTE_FIRST) begin
               first_byte_in = item.data_byte;
               byte_index_in = mpct_pkg::BYTE_SECOND;
            end else if (byte_index_ff == mpct_pkg::BYTE_SECOND) begin
               second_byte_in = item.data_byte;
               byte_index_in  = mpct_pkg::BYTE_THIRD;
            end else begin
               byte_index_in = mpct_pkg::BYTE_FIRST;
               btn_prev_in   = btn_now_ff;
               btn_now_in    = first_byte_ff[2:0];
               last_dx_in    = dx_new;
               last_dy_in    = dy_new;
               col_in        = mpct_pkg::move_clamped(col_ff, step_x, cfg.max_col);
               row_in        = mpct_pkg::move_clamped(row_ff, step_y, cfg.max_row);
               done          = 1'b1;
            end
         end else begin
            // drop the byte while disabled
         end
      end
   end

   // Build the result
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = done;
         rsp_tdata_in  = {
            ~btn_now_in[1] &  btn_prev_in[1],
            ~btn_now_in[0] &  btn_prev_in[0],
             btn_now_in[1] & ~btn_prev_in[1],
             btn_now_in[0] & ~btn_prev_in[0],
            last_dy_in,
            last_dx_in,
            btn_now_in,
            mpct_pkg::pos_byte(row_in),
            mpct_pkg::pos_byte(col_in)
         };
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= mpct_pkg::BYTE_FIRST;
         first_byte_ff  <= 8'd0;
         second_byte_ff <= 8'd0;
         col_ff         <= PW'(mpct_pkg::COL_RESET);
         row_ff         <= PW'(mpct_pkg::ROW_RESET);
         btn_now_ff     <= 3'd0;
         btn_prev_ff    <= 3'd0;
         last_dx_ff     <= 8'sd0;
         last_dy_ff     <= 9'sd0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         byte_index_ff  <= byte_index_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         btn_now_ff     <= btn_now_in;
         btn_prev_ff    <= btn_prev_in;
         last_dx_ff     <= last_dx_in;
         last_dy_ff     <= last_dy_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   // Byte counter never reaches the unused code
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff != 2'd3)
      else $error("byte index out of range");

   // A completed packet restarts gathering
   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      (load && done) |=> (byte_index_ff == mpct_pkg::BYTE_FIRST && rsp_tlast_ff))
      else $error("packet completion did not restart byte gathering");

   // Cursor after a packet stays inside the limits in force
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (load && done) |=> ({8'd0, col_ff} <= {8'd0, $past(cfg.max_col)} || col_ff == '1)
                      && ({8'd0, row_ff} <= {8'd0, $past(cfg.max_row)} || row_ff == '1))
      else $error("cursor outside clamp limits");

   // Nothing changes while the result is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> ($stable(col_ff) && $stable(row_ff)
                                          && $stable(byte_index_ff)))
      else $error("state moved while result stalled");
`endif

endmodule

// ===== sv/mouse_packet_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Gathers mouse bytes into three-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per item: req_tuser is the command (mouse
//   byte or set-position), req_tdata holds the byte and the position to load.
//   rsp_* returns exactly one transaction per accepted item: cursor, buttons,
//   last deltas and button edges in rsp_tdata, and rsp_tlast set when the
//   item completed a packet.
//   csr_we/csr_index/csr_wdata write enable, max_col and max_row; write them
//   only while no item is in flight.
// Timing:
//   An accepted item is captured in the input register, then updates the
//   packet state and result register, and leaves from the result register
//   when rsp_tready is high. One item is taken every cycle while rsp_tready
//   is high; the input register and result register keep both sides
//   moving.
// Reset:
//   Disabled, limits 79 and 24, cursor at column 40, row 12, no buttons,
//   zero deltas, no packet in progress.
// Stall:
//   When rsp_tready is low the result holds, the input register fills, and
//   req_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mpct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // data_byte[7:0], new_col[15:8], new_row[23:16]
   input  logic [mpct_pkg::REQ_W-1:0]   req_tdata,
   // command
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // cursor_col[7:0], cursor_row[15:8], button_bits[18:16], delta_x[26:19],
   // delta_y[35:27], left_press[36], right_press[37], left_release[38],
   // right_release[39]
   output logic [mpct_pkg::RSP_W-1:0]   rsp_tdata,
   // packet_done
   output logic                         rsp_tlast
);

   mpct_pkg::csr_type  cfg;
   mpct_pkg::item_type item;
   logic               item_valid;
   logic               item_take;

   mpct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpct_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   mpct_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
